// ----- sv/first_fit_heap_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define FFHA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define FFHA_ASSERT(label, clk, rst_n, prop)
`define FFHA_ASSERT_NR(label, clk, prop)
`endif
`endif

// ----- sv/ffha_pkg.sv -----
// ---------------------------------------------------------------------------
// ffha_pkg
// Constants and codes shared by the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;
  localparam int MaxBlocks   = 64;
  localparam int AlignBytes  = 16;
  localparam int HeaderBytes = 16;
  localparam int IdxW  = $clog2(MaxBlocks);
  localparam int CntW  = $clog2(MaxBlocks + 1);
  localparam int AlgW  = $clog2(AlignBytes);

  typedef logic [1:0] action_t;
  typedef logic [2:0] status_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam action_t ACT_ALLOC  = 2'd0;
  localparam action_t ACT_FREE   = 2'd1;
  localparam action_t ACT_REINIT = 2'd2;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_ZERO     = 3'd1;
  localparam status_t ST_NOMEM    = 3'd2;
  localparam status_t ST_BADFREE  = 3'd3;
  localparam status_t ST_BADRANGE = 3'd4;
  localparam status_t ST_SMALL    = 3'd5;
  localparam status_t ST_NULLFREE = 3'd6;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef struct packed {
    logic [31:0] hdr;
    logic [31:0] size;
    logic        used;
  } entry_t;
endpackage

// ----- sv/first_fit_heap_allocator.sv -----
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator over an address-ordered block table in one RAM.
// ---------------------------------------------------------------------------
// channel | dir | handshake        | words
// in_     | in  | in_valid/stall   | action, request_size, block_address
// out_    | out | out_valid/stall  | payload_address, status
// cfg_    | in  | cfg_valid/ready  | index, write data
// An allocate scans the table with a read state and a check state per entry,
// since the RAM read is registered, and then shifts entries up to insert a
// split, with a read and a write per moved entry. A free scans, then merges
// neighbors by shifting the tail down.
// Reset clears the block count, state, output valid and heap bounds; no clearing pass is needed.
// The input is taken only while the block is idle and the output is empty.
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ffha_pkg::action_t      in_action,
  input  logic [31:0]            in_request_size,
  input  logic [31:0]            in_block_address,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_payload_address,
  output ffha_pkg::status_t      out_status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_data
);
  import ffha_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;
  localparam logic [3:0] S_SCHK  = 4'd2;
  localparam logic [3:0] S_IRD   = 4'd3;
  localparam logic [3:0] S_IWR   = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_MRD   = 4'd6;
  localparam logic [3:0] S_MCHK  = 4'd7;
  localparam logic [3:0] S_RRD   = 4'd8;
  localparam logic [3:0] S_RWR   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  entry_t mem [MaxBlocks];
  entry_t rd_q;
  idx_t   rd_addr;
  logic   we;
  idx_t   wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  logic [3:0]  state_r, state_nxt;
  logic [31:0] hs_r, hl_r;
  action_t     act_r;
  logic [31:0] addr_r;
  logic [32:0] rsz_r;
  cnt_t        cnt_r, cnt_nxt;
  cnt_t        i_r, i_nxt;
  cnt_t        k_r, k_nxt;
  cnt_t        rm_r, rm_nxt;
  cnt_t        base_r, base_nxt;
  logic        pass2_r, pass2_nxt;
  entry_t      cur_r, cur_nxt;
  entry_t      split_r, split_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  status_t     res_st_r, res_st_nxt;

  logic        accept;
  logic [32:0] as_w, ae_w;

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_payload_address = res_addr_r;
  assign out_status = res_st_r;

  assign as_w = ({1'b0, hs_r} + 33'(AlignBytes - 1)) & ~33'(AlignBytes - 1);
  assign ae_w = {1'b0, hl_r} & ~33'(AlignBytes - 1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;
    k_nxt = k_r;
    rm_nxt = rm_r;
    base_nxt = base_r;
    pass2_nxt = pass2_r;
    cur_nxt = cur_r;
    split_nxt = split_r;
    ov_nxt = ov_r && out_stall;
    res_addr_nxt = res_addr_r;
    res_st_nxt = res_st_r;
    rd_addr = i_r[IdxW-1:0];
    we = 1'b0;
    wr_addr = i_r[IdxW-1:0];
    wr_data = cur_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          i_nxt = '0;
          res_addr_nxt = '0;
          res_st_nxt = ST_OK;
          pass2_nxt = 1'b0;
          unique case (in_action)
            ACT_ALLOC: begin
              if (in_request_size == '0) begin
                res_st_nxt = ST_ZERO;
                state_nxt = S_DONE;
              end else if ((({1'b0, in_request_size} + 33'(AlignBytes - 1)) >> 32) != '0) begin
                res_st_nxt = ST_NOMEM;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SRD;
              end
            end
            ACT_FREE: begin
              if (in_block_address == '0) begin
                res_st_nxt = ST_NULLFREE;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SRD;
              end
            end
            ACT_REINIT: state_nxt = S_RRD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RRD: begin
        if (hl_r <= hs_r) begin
          res_st_nxt = ST_BADRANGE;
          state_nxt = S_DONE;
        end else if (ae_w <= as_w || (ae_w - as_w) <= 33'(HeaderBytes)) begin
          res_st_nxt = ST_SMALL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RWR;
        end
      end
      S_RWR: begin
        we = 1'b1;
        wr_addr = '0;
        wr_data.hdr = as_w[31:0];
        wr_data.size = 32'(ae_w - as_w - 33'(HeaderBytes));
        wr_data.used = 1'b0;
        cnt_nxt = cnt_t'(1);
        state_nxt = S_DONE;
      end
      S_SRD: begin
        if (i_r >= cnt_r) begin
          res_st_nxt = (act_r == ACT_ALLOC) ? ST_NOMEM : ST_BADFREE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        cur_nxt = rd_q;
        if (act_r == ACT_ALLOC) begin
          if (!rd_q.used && {1'b0, rd_q.size} >= rsz_r) begin
            res_addr_nxt = rd_q.hdr + 32'(HeaderBytes);
            if ({1'b0, rd_q.size} >= rsz_r + 33'(HeaderBytes + AlignBytes) &&
                cnt_r < cnt_t'(MaxBlocks)) begin
              split_nxt.hdr = rd_q.hdr + 32'(HeaderBytes) + rsz_r[31:0];
              split_nxt.size = rd_q.size - rsz_r[31:0] - 32'(HeaderBytes);
              split_nxt.used = 1'b0;
              cur_nxt.size = rsz_r[31:0];
              k_nxt = cnt_r;
              state_nxt = S_IRD;
            end else begin
              state_nxt = S_IWR;
              k_nxt = i_r;
            end
            cur_nxt.used = 1'b1;
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_SRD;
          end
        end else begin
          if (rd_q.hdr + 32'(HeaderBytes) == addr_r) begin
            if (!rd_q.used) begin
              res_st_nxt = ST_BADFREE;
              state_nxt = S_DONE;
            end else begin
              cur_nxt.used = 1'b0;
              base_nxt = i_r;
              k_nxt = i_r + 1'b1;
              rm_nxt = i_r + 1'b1;
              state_nxt = S_MRD;
            end
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      // Shift entries up from the top, then write the found and split entries.
      S_IRD: begin
        rd_addr = IdxW'(k_r - 1'b1);
        if (k_r == i_r + 1'b1) begin
          we = 1'b1;
          wr_addr = IdxW'(k_r);
          wr_data = split_r;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_IWR;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        wr_addr = IdxW'(k_r);
        wr_data = rd_q;
        k_nxt = k_r - 1'b1;
        state_nxt = S_IRD;
      end
      S_IWR: begin
        we = 1'b1;
        wr_addr = i_r[IdxW-1:0];
        wr_data = cur_r;
        state_nxt = S_DONE;
      end
      // Merge: cur_r is entry base_r; k_r reads forward, rm_r is the write slot.
      S_MRD: begin
        rd_addr = IdxW'(k_r);
        if (k_r >= cnt_r) begin
          we = 1'b1;
          wr_addr = IdxW'(base_r);
          wr_data = cur_r;
          cnt_nxt = rm_r;
          k_nxt = rm_r;
          if (!pass2_r && base_r != '0) begin
            rd_addr = IdxW'(base_r - 1'b1);
            pass2_nxt = 1'b1;
            i_nxt = base_r - 1'b1;
            state_nxt = S_MCHK;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (pass2_r && base_r == i_r + 1'b1 && k_r == rm_r) begin
          // Second pass start: rd_q holds the previous entry.
          rd_addr = IdxW'(i_r);
          if (rd_q.used || cur_r.used) begin
            state_nxt = S_DONE;
          end else begin
            cur_nxt.hdr = rd_q.hdr;
            cur_nxt.size = rd_q.size + 32'(HeaderBytes) + cur_r.size;
            cur_nxt.used = 1'b0;
            base_nxt = i_r;
            k_nxt = base_r + 1'b1;
            rm_nxt = base_r;
            state_nxt = S_MRD;
          end
        end else if (k_r == rm_r && !rd_q.used && !cur_r.used) begin
          cur_nxt.size = cur_r.size + 32'(HeaderBytes) + rd_q.size;
          k_nxt = k_r + 1'b1;
          state_nxt = S_MRD;
        end else if (k_r == rm_r) begin
          // Nothing merged, so the rest of the table stays where it is.
          k_nxt = cnt_r;
          rm_nxt = cnt_r;
          state_nxt = S_MRD;
        end else begin
          we = 1'b1;
          wr_addr = IdxW'(rm_r);
          wr_data = rd_q;
          k_nxt = k_r + 1'b1;
          rm_nxt = rm_r + 1'b1;
          state_nxt = S_MRD;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
      hs_r <= '0;
      hl_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START) begin
          hs_r <= cfg_data;
        end else begin
          hl_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      addr_r <= in_block_address;
      rsz_r <= ({1'b0, in_request_size} + 33'(AlignBytes - 1)) & ~33'(AlignBytes - 1);
    end
    i_r <= i_nxt;
    k_r <= k_nxt;
    rm_r <= rm_nxt;
    base_r <= base_nxt;
    pass2_r <= pass2_nxt;
    cur_r <= cur_nxt;
    split_r <= split_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r <= res_st_nxt;
  end

  `FFHA_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= cnt_t'(MaxBlocks))
  `FFHA_ASSERT(a_no_accept_busy, clk, rst_n, (state_r != S_IDLE) |-> !accept)
  `FFHA_ASSERT(a_done_valid, clk, rst_n, (state_r == S_DONE) |=> out_valid)
  `FFHA_ASSERT(a_ok_addr, clk, rst_n,
    (out_valid && out_payload_address != '0) |-> out_status == ST_OK)
endmodule

// ----- test/testbench.sv -----
// ---------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate, free and reinit words through several heap settings,
// predicts each result from a private copy of the block table and compares
// every returned word field by field, with random input gaps and stalls.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  typedef struct packed {
    action_t     act;
    logic [31:0] size;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [31:0] paddr;
    status_t     st;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  action_t in_action = ACT_ALLOC;
  logic [31:0] in_request_size = '0;
  logic [31:0] in_block_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_payload_address;
  status_t out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_START;
  logic [31:0] cfg_data = '0;

  first_fit_heap_allocator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t pending_words[$];
  resp_t expected_results[$];
  logic [31:0] live_addrs[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int cycle_count = 0;
  int burst_left = 0;

  logic [63:0] m_start, m_limit;
  logic [31:0] m_hdr[MaxBlocks];
  logic [31:0] m_size[MaxBlocks];
  logic m_used[MaxBlocks];
  int m_count;
  int st_hits[8];

  function automatic logic [63:0] align_up(logic [63:0] x);
    return ((x + AlignBytes - 1) / AlignBytes) * AlignBytes;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < m_count; k++) begin
      m_hdr[k] = m_hdr[k+1];
      m_size[k] = m_size[k+1];
      m_used[k] = m_used[k+1];
    end
    m_count--;
  endfunction

  function automatic void merge_up(int idx);
    if (idx >= m_count || m_used[idx]) return;
    while (idx + 1 < m_count && !m_used[idx+1]) begin
      m_size[idx] = m_size[idx] + HeaderBytes + m_size[idx+1];
      drop_entry(idx + 1);
    end
  endfunction

  function automatic resp_t heap_predict(req_t w);
    resp_t r;
    logic [63:0] rs, as, ae;
    int i;
    r = '{paddr: '0, st: ST_OK};
    if (w.act == ACT_ALLOC) begin
      if (w.size == 0) r.st = ST_ZERO;
      else begin
        rs = align_up({32'd0, w.size});
        i = m_count;
        if (rs <= 64'hFFFF_FFFF)
          for (i = 0; i < m_count; i++)
            if (!m_used[i] && {32'd0, m_size[i]} >= rs) break;
        if (i >= m_count) r.st = ST_NOMEM;
        else begin
          if ({32'd0, m_size[i]} >= rs + HeaderBytes + AlignBytes && m_count < MaxBlocks) begin
            for (int k = m_count; k > i + 1; k--) begin
              m_hdr[k] = m_hdr[k-1];
              m_size[k] = m_size[k-1];
              m_used[k] = m_used[k-1];
            end
            m_hdr[i+1] = m_hdr[i] + HeaderBytes + rs[31:0];
            m_size[i+1] = m_size[i] - rs[31:0] - HeaderBytes;
            m_used[i+1] = 1'b0;
            m_size[i] = rs[31:0];
            m_count++;
          end
          m_used[i] = 1'b1;
          r.paddr = m_hdr[i] + HeaderBytes;
        end
      end
    end else if (w.act == ACT_FREE) begin
      if (w.addr == 0) r.st = ST_NULLFREE;
      else begin
        for (i = 0; i < m_count; i++)
          if ({32'd0, m_hdr[i]} + HeaderBytes == {32'd0, w.addr}) break;
        if (i >= m_count || !m_used[i]) r.st = ST_BADFREE;
        else begin
          m_used[i] = 1'b0;
          merge_up(i);
          if (i > 0) merge_up(i - 1);
        end
      end
    end else if (w.act == ACT_REINIT) begin
      if (m_limit <= m_start) r.st = ST_BADRANGE;
      else begin
        as = align_up(m_start);
        ae = m_limit - (m_limit % AlignBytes);
        if (ae <= as || ae - as <= HeaderBytes) r.st = ST_SMALL;
        else begin
          m_hdr[0] = as[31:0];
          m_size[0] = 32'(ae - as - HeaderBytes);
          m_used[0] = 1'b0;
          m_count = 1;
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  always @(posedge clk) begin
    req_t w;
    cycle_count <= cycle_count + 1;
    if (in_valid && !in_stall) n_sent <= n_sent + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (burst_left > 0 && pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_action <= w.act;
        in_request_size <= w.size;
        in_block_address <= w.addr;
        burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 3) == 0) burst_left <= $urandom_range(1, 20);
      end
    end
  end

  always @(posedge clk) begin
    resp_t e;
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (cycle_count % 512 < 200) ? 1'b0 : ($urandom_range(0, 3) == 0);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected word", out_payload_address, 32'd0);
      end else begin
        e = expected_results.pop_front();
        if (out_payload_address !== e.paddr) report("payload_address", out_payload_address, e.paddr);
        if (out_status !== e.st) report("status", {29'd0, out_status}, {29'd0, e.st});
      end
      n_checked <= n_checked + 1;
    end
  end

  always @(posedge clk)
    if (cycle_count > 3000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end

  task automatic push_word(action_t a, logic [31:0] s, logic [31:0] ad);
    req_t w;
    resp_t r;
    w = '{act: a, size: s, addr: ad};
    r = heap_predict(w);
    st_hits[r.st]++;
    if (a == ACT_ALLOC && r.st == ST_OK) live_addrs.push_back(r.paddr);
    expected_results.push_back(r);
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_START) m_start = {32'd0, v};
    else m_limit = {32'd0, v};
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom;
      2: return $urandom_range(1, 4096);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  task automatic random_phase(int n);
    int j;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: push_word(ACT_REINIT, 0, 0);
        1: push_word(action_t'(3), $urandom, $urandom);
        2: push_word(ACT_FREE, 0, 0);
        3: push_word(ACT_FREE, $urandom, $urandom);
        4, 5, 6, 7, 8, 9, 10: begin
          if (live_addrs.size() > 0) begin
            j = $urandom_range(0, live_addrs.size() - 1);
            push_word(ACT_FREE, $urandom, live_addrs[j]);
            live_addrs.delete(j);
          end else push_word(ACT_FREE, $urandom, m_start[31:0] + 16);
        end
        default: push_word(ACT_ALLOC, rand_size(), $urandom);
      endcase
    end
  endtask

  initial begin
    m_start = 0;
    m_limit = 0;
    m_count = 0;
    foreach (st_hits[i]) st_hits[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_word(ACT_ALLOC, 32, 0);
    push_word(ACT_REINIT, 0, 0);
    push_word(ACT_FREE, 0, 0);
    wait_drained();
    write_reg(CFG_START, 32'h0000_1003);
    write_reg(CFG_LIMIT, 32'h0000_100F);
    push_word(ACT_REINIT, 0, 0);
    wait_drained();
    write_reg(CFG_LIMIT, 32'h0000_1030);
    push_word(ACT_REINIT, 0, 0);
    wait_drained();
    write_reg(CFG_START, 32'h0000_1000);
    write_reg(CFG_LIMIT, 32'h0000_1800);
    push_word(ACT_REINIT, 0, 0);
    push_word(ACT_ALLOC, 0, 0);
    push_word(ACT_ALLOC, 32'hFFFF_FFFF, 0);
    push_word(ACT_ALLOC, 32'hFFFF_FFF1, 0);
    push_word(ACT_ALLOC, 1, 0);
    push_word(ACT_ALLOC, 16, 0);
    push_word(ACT_ALLOC, 100, 0);
    push_word(ACT_FREE, 0, 32'h0000_1020);
    push_word(ACT_FREE, 0, 32'h0000_1020);
    push_word(ACT_FREE, 0, 32'h0000_1010);
    push_word(ACT_FREE, 0, 32'hFFFF_FFFF);
    push_word(action_t'(3), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(ACT_ALLOC, 32'h0000_07E0, 0);
    for (int k = 0; k < 70; k++) push_word(ACT_ALLOC, 16, 0);
    wait_drained();

    live_addrs.delete();
    write_reg(CFG_START, 32'h0000_0000);
    write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
    push_word(ACT_REINIT, 0, 0);
    random_phase(450);
    wait_drained();

    live_addrs.delete();
    write_reg(CFG_START, $urandom);
    write_reg(CFG_LIMIT, $urandom);
    push_word(ACT_REINIT, 0, 0);
    random_phase(50);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      live_addrs.delete();
      write_reg(CFG_START, $urandom & 32'hFFFF_0FFF);
      write_reg(CFG_LIMIT, m_start[31:0] + $urandom_range(40, 6000));
      push_word(ACT_REINIT, 0, 0);
      random_phase(300);
      wait_drained();
    end

    write_reg(CFG_START, 32'hFFFF_FFF0);
    write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
    push_word(ACT_REINIT, 0, 0);
    random_phase(20);
    wait_drained();

    $display("checked %0d result words from %0d input words over 10 heap settings", n_checked,
             n_sent);
    $display("status counts ok %0d zero %0d nomem %0d badfree %0d range %0d small %0d null %0d",
             st_hits[0], st_hits[1], st_hits[2], st_hits[3], st_hits[4], st_hits[5], st_hits[6]);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
